FILE: rtl/iou_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iou_pkg;

   // Table size and coordinate width.
   localparam int MAX_TRUTH  = 32;
   localparam int COORD_BITS = 12;

   localparam int SIZE_BITS  = COORD_BITS - 1;
   localparam int EDGE_BITS  = COORD_BITS + 1;
   localparam int DIFF_BITS  = COORD_BITS + 2;
   localparam int AREA_BITS  = 2 * SIZE_BITS;
   localparam int UNION_BITS = AREA_BITS + 1;

   // Threshold is Q0.8 with one extra integer bit so that 256 means 1.0.
   localparam int THR_FRAC    = 8;
   localparam int THR_BITS    = THR_FRAC + 1;
   localparam int PROD_BITS   = THR_BITS + UNION_BITS;
   localparam int SCALED_BITS = AREA_BITS + THR_FRAC;
   localparam int PAD_BITS    = PROD_BITS - SCALED_BITS;

   localparam int IDX_W = (MAX_TRUTH > 1) ? $clog2(MAX_TRUTH) : 1;
   localparam int CNT_W = $clog2(MAX_TRUTH + 1);

   localparam int LARGE_BITS    = 11;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 11;

   localparam logic [THR_BITS-1:0]   THR_RESET   = THR_BITS'(128);
   localparam logic [LARGE_BITS-1:0] LARGE_RESET = LARGE_BITS'(50);

   // Register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_IOU_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LARGE_HEIGHT  = 1'b1;

   // Request commands.
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_JUDGE = 2'd1;
   localparam logic [1:0] CMD_FRAME = 2'd2;

   // Response kinds.
   localparam logic [1:0] KIND_VERDICT   = 2'd0;
   localparam logic [1:0] KIND_UNMATCHED = 2'd1;
   localparam logic [1:0] KIND_DONE      = 2'd2;

   typedef struct packed {
      logic [1:0]                   command;
      logic signed [COORD_BITS-1:0] box_x;
      logic signed [COORD_BITS-1:0] box_y;
      logic [SIZE_BITS-1:0]         box_width;
      logic [SIZE_BITS-1:0]         box_height;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]                   kind;
      logic                         positive;
      logic                         large_res;
      logic                         no_overlap;
      logic signed [COORD_BITS-1:0] out_x;
      logic signed [COORD_BITS-1:0] out_y;
      logic [SIZE_BITS-1:0]         out_width;
      logic [SIZE_BITS-1:0]         out_height;
      logic                         table_full;
      logic                         last;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [SIZE_BITS-1:0]         w;
      logic [SIZE_BITS-1:0]         h;
   } truth_box_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } pipe_issue_type;

   typedef struct packed {
      logic             busy;
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic             hit;
      logic             reach;
   } pipe_status_type;

endpackage

`default_nettype wire

FILE: rtl/iou_detection_matcher.sv
`timescale 1ns / 1ps
`default_nettype none

// Load request: no response; the matcher stays idle, so a new request can follow in the next cycle.
// Detection request: all stored boxes are swept through the overlap pipe; once it drains the verdict
// is issued, held by any response stall; an empty table skips the sweep. The next request follows it.
// End of frame: each unmatched box is reported in table order, matched boxes are skipped, then the done item.
// Reset (synchronous): clears the box count, matched marks, overflow flag and FSM;
// threshold returns to 128 and large height to 50. Box memory is not cleared.

module iou_detection_matcher (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire iou_pkg::req_payload_type        req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output iou_pkg::rsp_payload_type             rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [iou_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [iou_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import iou_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_JUDGE     = 7'b0000010,
      ST_DRAIN     = 7'b0000100,
      ST_VERDICT   = 7'b0001000,
      ST_FLUSH     = 7'b0010000,
      ST_FLUSH_OUT = 7'b0100000,
      ST_DONE      = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Control state.
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [MAX_TRUTH-1:0] marks_ff, marks_in;
   logic                 overflow_ff, overflow_in;
   logic                 pos_ff, pos_in;
   logic                 any_ff, any_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [THR_BITS-1:0]  thr_ff;
   logic [LARGE_BITS-1:0] large_ff;

   // Payload registers.
   rsp_payload_type      rsp_data_ff, rsp_data_in;
   truth_box_type        det_ff;
   logic [AREA_BITS-1:0] det_area_ff;

   logic                 req_accept;
   logic                 slot_free;
   logic                 judge_start;
   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     cur_idx;
   truth_box_type        req_box;
   truth_box_type        ram_rd_data;
   pipe_issue_type       issue;
   pipe_status_type      pipe_status;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign cur_idx    = idx_ff[IDX_W-1:0];

   assign req_box.x = req_data.box_x;
   assign req_box.y = req_data.box_y;
   assign req_box.w = req_data.box_width;
   assign req_box.h = req_data.box_height;

   assign judge_start = req_accept && (req_data.command == CMD_JUDGE);

   // Loads go into the next free row; a load into a full table is dropped.
   assign ram_wr_en = req_accept && (req_data.command == CMD_LOAD)
                      && (count_ff < CNT_W'(MAX_TRUTH));

   // The sweep reads one row per cycle while judging; the frame flush reads
   // only rows whose box was never matched.
   assign ram_rd_en = (state_ff == ST_JUDGE)
                      || ((state_ff == ST_FLUSH) && (idx_ff != count_ff)
                          && !marks_ff[cur_idx]);

   assign issue.valid = (state_ff == ST_JUDGE);
   assign issue.idx   = cur_idx;

   iou_box_ram u_box_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_box),
      .rd_en   (ram_rd_en),
      .rd_addr (cur_idx),
      .rd_data (ram_rd_data)
   );

   iou_overlap_pipe u_overlap_pipe (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .truth     (ram_rd_data),
      .det       (det_ff),
      .det_area  (det_area_ff),
      .threshold (thr_ff),
      .status    (pipe_status)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      marks_in     = marks_ff;
      overflow_in  = overflow_ff;
      pos_in       = pos_ff;
      any_in       = any_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      // Results leaving the overlap pipe update the verdict and the marks.
      if (pipe_status.valid && pipe_status.hit) begin
         any_in = 1'b1;
         if (pipe_status.reach) begin
            pos_in                    = 1'b1;
            marks_in[pipe_status.idx] = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_data.command)
                  CMD_LOAD: begin
                     if (ram_wr_en) begin
                        marks_in[count_ff[IDX_W-1:0]] = 1'b0;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  CMD_JUDGE: begin
                     pos_in   = 1'b0;
                     any_in   = 1'b0;
                     idx_in   = '0;
                     state_in = (count_ff == '0) ? ST_VERDICT : ST_JUDGE;
                  end
                  CMD_FRAME: begin
                     idx_in   = '0;
                     state_in = ST_FLUSH;
                  end
                  default: begin
                     // The unused command is dropped without a response.
                  end
               endcase
            end
         end
         ST_JUDGE: begin
            if (idx_ff == count_ff - CNT_W'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!pipe_status.busy) begin
               state_in = ST_VERDICT;
            end
         end
         ST_VERDICT: begin
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.kind       = KIND_VERDICT;
               rsp_data_in.positive   = pos_ff;
               rsp_data_in.large_res  = ({1'b0, det_ff.h} > {1'b0, large_ff});
               rsp_data_in.no_overlap = !any_ff;
               rsp_data_in.out_x      = det_ff.x;
               rsp_data_in.out_y      = det_ff.y;
               rsp_data_in.out_width  = det_ff.w;
               rsp_data_in.out_height = det_ff.h;
               rsp_data_in.table_full = 1'b0;
               rsp_data_in.last       = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (idx_ff == count_ff) begin
               state_in = ST_DONE;
            end else if (marks_ff[cur_idx]) begin
               idx_in = idx_ff + CNT_W'(1);
            end else begin
               state_in = ST_FLUSH_OUT;
            end
         end
         ST_FLUSH_OUT: begin
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.kind       = KIND_UNMATCHED;
               rsp_data_in.positive   = 1'b0;
               rsp_data_in.large_res  = 1'b0;
               rsp_data_in.no_overlap = 1'b0;
               rsp_data_in.out_x      = ram_rd_data.x;
               rsp_data_in.out_y      = ram_rd_data.y;
               rsp_data_in.out_width  = ram_rd_data.w;
               rsp_data_in.out_height = ram_rd_data.h;
               rsp_data_in.table_full = 1'b0;
               rsp_data_in.last       = 1'b0;
               idx_in                 = idx_ff + CNT_W'(1);
               state_in               = ST_FLUSH;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.kind       = KIND_DONE;
               rsp_data_in.positive   = 1'b0;
               rsp_data_in.large_res  = 1'b0;
               rsp_data_in.no_overlap = 1'b0;
               rsp_data_in.out_x      = '0;
               rsp_data_in.out_y      = '0;
               rsp_data_in.out_width  = '0;
               rsp_data_in.out_height = '0;
               rsp_data_in.table_full = overflow_ff;
               rsp_data_in.last       = 1'b1;
               count_in               = '0;
               marks_in               = '0;
               overflow_in            = 1'b0;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         marks_ff     <= '0;
         overflow_ff  <= 1'b0;
         pos_ff       <= 1'b0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THR_RESET;
         large_ff     <= LARGE_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         marks_ff     <= marks_in;
         overflow_ff  <= overflow_in;
         pos_ff       <= pos_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IOU_THRESHOLD: thr_ff   <= csr_data[THR_BITS-1:0];
               CSR_LARGE_HEIGHT:  large_ff <= csr_data[LARGE_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // The detection box and its area are held for the whole sweep.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (judge_start) begin
         det_ff      <= req_box;
         det_area_ff <= {{SIZE_BITS{1'b0}}, req_data.box_width}
                        * {{SIZE_BITS{1'b0}}, req_data.box_height};
      end
   end

   // The box count never passes the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TRUTH))
      else $error("box count exceeds table size");

   // A new request is only taken once the overlap pipe has drained.
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !pipe_status.busy)
      else $error("request taken while the overlap pipe is busy");

   // A box reported as unmatched never carries a matched mark.
   a_flush_unmatched: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH_OUT) |-> !marks_ff[cur_idx])
      else $error("matched box reported as unmatched");

   // Issuing the done item empties the table for the next frame.
   a_frame_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && slot_free)
      |=> (count_ff == '0 && marks_ff == '0 && !overflow_ff))
      else $error("table not cleared at end of frame");

endmodule

`default_nettype wire

FILE: rtl/iou_box_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module iou_box_ram (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [iou_pkg::IDX_W-1:0] wr_addr,
   input  wire iou_pkg::truth_box_type wr_data,
   input  wire logic                  rd_en,
   input  wire logic [iou_pkg::IDX_W-1:0] rd_addr,
   output iou_pkg::truth_box_type     rd_data
);
   import iou_pkg::*;

   truth_box_type mem_ff [MAX_TRUTH];
   truth_box_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data is registered and holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/iou_overlap_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module iou_overlap_pipe (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire iou_pkg::pipe_issue_type    issue,
   input  wire iou_pkg::truth_box_type     truth,
   input  wire iou_pkg::truth_box_type     det,
   input  wire logic [iou_pkg::AREA_BITS-1:0] det_area,
   input  wire logic [iou_pkg::THR_BITS-1:0]  threshold,
   output iou_pkg::pipe_status_type        status
);
   import iou_pkg::*;

   // Stage R: aligns with the registered memory read data.
   logic             r_valid_ff;
   logic [IDX_W-1:0] r_idx_ff;
   // Stage A: intersection extents.
   logic             a_valid_ff;
   logic [IDX_W-1:0] a_idx_ff;
   logic             a_hit_ff;
   logic [SIZE_BITS-1:0] a_iw_ff, a_ih_ff, a_tw_ff, a_th_ff;
   // Stage B: intersection and stored-box areas.
   logic             b_valid_ff;
   logic [IDX_W-1:0] b_idx_ff;
   logic             b_hit_ff;
   logic [AREA_BITS-1:0] b_inter_ff, b_tarea_ff;
   // Stage C: union area.
   logic             c_valid_ff;
   logic [IDX_W-1:0] c_idx_ff;
   logic             c_hit_ff;
   logic [AREA_BITS-1:0]  c_inter_ff;
   logic [UNION_BITS-1:0] c_union_ff;
   // Stage D: threshold product and scaled intersection.
   logic             d_valid_ff;
   logic [IDX_W-1:0] d_idx_ff;
   logic             d_hit_ff;
   logic [PROD_BITS-1:0]   d_prod_ff;
   logic [SCALED_BITS-1:0] d_scaled_ff;

   logic signed [EDGE_BITS-1:0]  t_end_x, d_end_x, t_end_y, d_end_y;
   logic signed [EDGE_BITS-1:0]  min_end_x, min_end_y;
   logic signed [COORD_BITS-1:0] max_x, max_y;
   logic [DIFF_BITS-1:0]         iw, ih;
   logic                         iw_pos, ih_pos;

   // The overlap along one axis is min(right edges) - max(left edges).
   always_comb begin
      t_end_x = {truth.x[COORD_BITS-1], truth.x} + {2'b00, truth.w};
      d_end_x = {det.x[COORD_BITS-1], det.x} + {2'b00, det.w};
      t_end_y = {truth.y[COORD_BITS-1], truth.y} + {2'b00, truth.h};
      d_end_y = {det.y[COORD_BITS-1], det.y} + {2'b00, det.h};
      min_end_x = (t_end_x < d_end_x) ? t_end_x : d_end_x;
      min_end_y = (t_end_y < d_end_y) ? t_end_y : d_end_y;
      max_x = (truth.x > det.x) ? truth.x : det.x;
      max_y = (truth.y > det.y) ? truth.y : det.y;
      iw = {min_end_x[EDGE_BITS-1], min_end_x} - {{2{max_x[COORD_BITS-1]}}, max_x};
      ih = {min_end_y[EDGE_BITS-1], min_end_y} - {{2{max_y[COORD_BITS-1]}}, max_y};
      iw_pos = !iw[DIFF_BITS-1] && (iw != '0);
      ih_pos = !ih[DIFF_BITS-1] && (ih != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= issue.valid;
         a_valid_ff <= r_valid_ff;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      r_idx_ff <= issue.idx;

      a_idx_ff <= r_idx_ff;
      a_hit_ff <= iw_pos && ih_pos;
      a_iw_ff  <= iw[SIZE_BITS-1:0];
      a_ih_ff  <= ih[SIZE_BITS-1:0];
      a_tw_ff  <= truth.w;
      a_th_ff  <= truth.h;

      b_idx_ff   <= a_idx_ff;
      b_hit_ff   <= a_hit_ff;
      b_inter_ff <= {{SIZE_BITS{1'b0}}, a_iw_ff} * {{SIZE_BITS{1'b0}}, a_ih_ff};
      b_tarea_ff <= {{SIZE_BITS{1'b0}}, a_tw_ff} * {{SIZE_BITS{1'b0}}, a_th_ff};

      c_idx_ff   <= b_idx_ff;
      c_hit_ff   <= b_hit_ff;
      c_inter_ff <= b_inter_ff;
      c_union_ff <= {1'b0, b_tarea_ff} + {1'b0, det_area} - {1'b0, b_inter_ff};

      d_idx_ff    <= c_idx_ff;
      d_hit_ff    <= c_hit_ff;
      d_prod_ff   <= {{UNION_BITS{1'b0}}, threshold} * {{THR_BITS{1'b0}}, c_union_ff};
      d_scaled_ff <= {c_inter_ff, {THR_FRAC{1'b0}}};
   end

   always_comb begin
      status.busy  = r_valid_ff || a_valid_ff || b_valid_ff || c_valid_ff || d_valid_ff;
      status.valid = d_valid_ff;
      status.idx   = d_idx_ff;
      status.hit   = d_hit_ff;
      status.reach = d_hit_ff && ({{PAD_BITS{1'b0}}, d_scaled_ff} >= d_prod_ff);
   end

endmodule

`default_nettype wire

FILE: dv/iou_detection_matcher_tb.sv
`timescale 1ns / 1ps

module iou_detection_matcher_tb;
   import iou_pkg::*;

   // Command 3 has no meaning to the matcher and must be dropped silently.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Loads give no response, so after the last response of a phase the matcher may
   // still be busy with trailing loads; this covers it.
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 38;
   localparam int SIZE_MAX      = (1 << SIZE_BITS) - 1;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_payload_type          req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_payload_type          rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data  = '0;

   // The testbench's own view of the matcher: the ground-truth table, the matched
   // marks, the fill level, the sticky overflow flag and both registers.
   truth_box_type         truth_table [MAX_TRUTH];
   bit                    matched_marks [MAX_TRUTH];
   int                    truth_count   = 0;
   bit                    overflow_seen = 1'b0;
   logic [THR_BITS-1:0]   iou_threshold = THR_RESET;
   logic [LARGE_BITS-1:0] large_height  = LARGE_RESET;

   // Requests waiting to be driven, and responses predicted but not yet seen.
   req_payload_type request_queue [$];
   rsp_payload_type report_queue [$];

   int idle_pct    = 0;
   int stim_count  = 0;
   int error_count = 0;
   int gap_left    = 0;
   int stall_left  = 0;

   iou_detection_matcher i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Updates the table for one accepted request and queues the responses that
   // it must cause. All areas are worked out in 64 bits, so the threshold test
   // inter*256 >= threshold*union is exact.
   task automatic match_request(input req_payload_type r);
      rsp_payload_type o;
      truth_box_type   t;
      longint          dx, dy, dw, dh, tx, ty, tw, th;
      longint          hi, lo, iw, ih, inter, uni;
      bit              any_hit, reached;
      dx = longint'(r.box_x);
      dy = longint'(r.box_y);
      dw = longint'(r.box_width);
      dh = longint'(r.box_height);
      case (r.command)
         CMD_LOAD: begin
            if (truth_count < MAX_TRUTH) begin
               truth_table[truth_count].x   = r.box_x;
               truth_table[truth_count].y   = r.box_y;
               truth_table[truth_count].w   = r.box_width;
               truth_table[truth_count].h   = r.box_height;
               matched_marks[truth_count] = 1'b0;
               truth_count++;
            end else begin
               // A full table drops the box, and the done item must say so.
               overflow_seen = 1'b1;
            end
         end
         CMD_JUDGE: begin
            any_hit = 1'b0;
            reached = 1'b0;
            for (int i = 0; i < truth_count; i++) begin
               t  = truth_table[i];
               tx = longint'(t.x);
               ty = longint'(t.y);
               tw = longint'(t.w);
               th = longint'(t.h);
               hi = (tx + tw > dx + dw) ? tx + tw : dx + dw;
               lo = (tx < dx) ? tx : dx;
               iw = tw + dw - (hi - lo);
               hi = (ty + th > dy + dh) ? ty + th : dy + dh;
               lo = (ty < dy) ? ty : dy;
               ih = th + dh - (hi - lo);
               // Boxes that only touch, or have a zero size, do not overlap.
               if (iw > 0 && ih > 0) begin
                  any_hit = 1'b1;
                  inter   = iw * ih;
                  uni     = tw * th + dw * dh - inter;
                  if (inter * 256 >= longint'(iou_threshold) * uni) begin
                     reached          = 1'b1;
                     matched_marks[i] = 1'b1;
                  end
               end
            end
            o            = '0;
            o.kind       = KIND_VERDICT;
            o.positive   = reached;
            o.large_res  = (r.box_height > large_height);
            o.no_overlap = !any_hit;
            o.out_x      = r.box_x;
            o.out_y      = r.box_y;
            o.out_width  = r.box_width;
            o.out_height = r.box_height;
            o.last       = 1'b1;
            report_queue = {report_queue, o};
         end
         CMD_FRAME: begin
            // Every box that no detection reached is reported in table order.
            for (int i = 0; i < truth_count; i++) begin
               if (!matched_marks[i]) begin
                  o            = '0;
                  o.kind       = KIND_UNMATCHED;
                  o.out_x      = truth_table[i].x;
                  o.out_y      = truth_table[i].y;
                  o.out_width  = truth_table[i].w;
                  o.out_height = truth_table[i].h;
                  report_queue = {report_queue, o};
               end
            end
            o            = '0;
            o.kind       = KIND_DONE;
            o.table_full = overflow_seen;
            o.last       = 1'b1;
            report_queue = {report_queue, o};
            truth_count   = 0;
            overflow_seen = 1'b0;
            for (int i = 0; i < MAX_TRUTH; i++) matched_marks[i] = 1'b0;
         end
         default: begin
         end
      endcase
   endtask

   // Request driver. A request is taken at an edge where valid and ready are both
   // high; only then, or while valid is low, may the next request be presented.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) match_request(req_data);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_queue.size() > 0 && idle_pct > 0 &&
                         $urandom_range(0, 99) < idle_pct) begin
               // Start a burst of idle cycles before the next request.
               gap_left = $urandom_range(1, 19) - 1;
               req_valid <= 1'b0;
            end else if (request_queue.size() > 0) begin
               req_data  <= request_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic signed [15:0] want,
                              input logic signed [15:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Response monitor. Every accepted response is checked against the oldest
   // prediction; the ready line stalls in random bursts.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (report_queue.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response, expected none, actual %p",
                        $time, rsp_data);
            end else begin
               want = report_queue.pop_front();
               check_field("kind", want.kind, rsp_data.kind);
               check_field("positive", want.positive, rsp_data.positive);
               check_field("large_res", want.large_res, rsp_data.large_res);
               check_field("no_overlap", want.no_overlap, rsp_data.no_overlap);
               check_field("out_x", want.out_x, rsp_data.out_x);
               check_field("out_y", want.out_y, rsp_data.out_y);
               check_field("out_width", want.out_width, rsp_data.out_width);
               check_field("out_height", want.out_height, rsp_data.out_height);
               check_field("table_full", want.table_full, rsp_data.table_full);
               check_field("last", want.last, rsp_data.last);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 2) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic queue_box(input logic [1:0] cmd, input int x, input int y,
                            input int w, input int h);
      req_payload_type r;
      r.command    = cmd;
      r.box_x      = x[COORD_BITS-1:0];
      r.box_y      = y[COORD_BITS-1:0];
      r.box_width  = w[SIZE_BITS-1:0];
      r.box_height = h[SIZE_BITS-1:0];
      request_queue = {request_queue, r};
      if (cmd != CMD_UNUSED) stim_count++;
   endtask

   // Mostly moderate boxes around the origin, sometimes every bit at random.
   function automatic truth_box_type random_box();
      truth_box_type b;
      if ($urandom_range(0, 5) == 0) begin
         b.x = COORD_BITS'($urandom);
         b.y = COORD_BITS'($urandom);
         b.w = SIZE_BITS'($urandom);
         b.h = SIZE_BITS'($urandom);
      end else begin
         b.x = COORD_BITS'(int'($urandom_range(0, 400)) - 200);
         b.y = COORD_BITS'(int'($urandom_range(0, 400)) - 200);
         b.w = SIZE_BITS'($urandom_range(1, 120));
         b.h = SIZE_BITS'($urandom_range(1, 120));
      end
      return b;
   endfunction

   // One frame: loads, then detections that are mostly jittered copies of the
   // loaded boxes so that the IoU lands near the threshold, then end of frame.
   // Heavy frames can overfill the table. Now and then an ignored command is mixed
   // in or the frame end is left out, so the next frame runs on.
   task automatic queue_frame(input bit heavy);
      truth_box_type loaded [$];
      truth_box_type b;
      int            n_loads, n_judges, sw, sh, w, h;
      n_loads  = heavy ? $urandom_range(30, 36) : $urandom_range(0, 8);
      n_judges = heavy ? $urandom_range(1, 4) : $urandom_range(0, 8);
      for (int i = 0; i < n_loads; i++) begin
         b = random_box();
         loaded = {loaded, b};
         queue_box(CMD_LOAD, int'(b.x), int'(b.y), int'(b.w), int'(b.h));
         if ($urandom_range(0, 19) == 0) begin
            b = random_box();
            queue_box(CMD_UNUSED, int'(b.x), int'(b.y), int'(b.w), int'(b.h));
         end
      end
      for (int i = 0; i < n_judges; i++) begin
         if (loaded.size() > 0 && $urandom_range(0, 3) != 0) begin
            b  = loaded[$urandom_range(0, loaded.size() - 1)];
            sw = int'(b.w) / 3 + 1;
            sh = int'(b.h) / 3 + 1;
            b.x = COORD_BITS'(int'(b.x) + int'($urandom_range(0, 2 * sw)) - sw);
            b.y = COORD_BITS'(int'(b.y) + int'($urandom_range(0, 2 * sh)) - sh);
            w = int'(b.w) + int'($urandom_range(0, 2 * sw)) - sw;
            h = int'(b.h) + int'($urandom_range(0, 2 * sh)) - sh;
            b.w = SIZE_BITS'((w < 0) ? 0 : (w > SIZE_MAX) ? SIZE_MAX : w);
            b.h = SIZE_BITS'((h < 0) ? 0 : (h > SIZE_MAX) ? SIZE_MAX : h);
         end else begin
            b = random_box();
         end
         queue_box(CMD_JUDGE, int'(b.x), int'(b.y), int'(b.w), int'(b.h));
      end
      if ($urandom_range(0, 9) != 0) begin
         // The box fields of an end of frame carry no meaning; fill them anyway.
         b = random_box();
         queue_box(CMD_FRAME, int'(b.x), int'(b.y), int'(b.w), int'(b.h));
      end
   endtask

   // Registers are only written while the matcher is idle.
   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_IOU_THRESHOLD) iou_threshold = value[THR_BITS-1:0];
      else large_height = value[LARGE_BITS-1:0];
      csr_valid <= 1'b0;
   endtask

   // Wait until every request is taken and every response has come back, then
   // give the matcher time to finish trailing loads.
   task automatic wait_drained();
      do @(negedge clock);
      while (request_queue.size() != 0 || req_valid || report_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int thr, height_limit;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, run with the reset values of both registers.
      idle_pct = 10;
      queue_box(CMD_FRAME, 0, 0, 0, 0);               // end of an empty frame
      queue_box(CMD_JUDGE, 5, 5, 10, 10);             // detection on an empty table
      queue_box(CMD_UNUSED, -1, -1, 2047, 2047);      // ignored command, all ones
      queue_box(CMD_LOAD, 0, 0, 10, 10);
      queue_box(CMD_LOAD, -2048, -2048, 2047, 2047);  // most negative corner, largest
      queue_box(CMD_LOAD, 2047, 2047, 0, 0);          // zero size never overlaps
      queue_box(CMD_LOAD, 100, 100, 20, 20);
      queue_box(CMD_JUDGE, 0, 0, 10, 20);             // IoU exactly one half
      queue_box(CMD_JUDGE, 0, 0, 10, 21);             // just below one half
      queue_box(CMD_JUDGE, 10, 0, 10, 10);            // shares only an edge
      queue_box(CMD_JUDGE, -1000, -1000, 51, 51);     // one above the large height
      queue_box(CMD_JUDGE, 0, 0, 2047, 50);           // height equal to the limit
      queue_box(CMD_JUDGE, 2047, 2047, 2047, 2047);   // far corner, nothing there
      queue_box(CMD_FRAME, 0, 0, 0, 0);               // three boxes left unmatched
      queue_box(CMD_LOAD, 0, 0, 0, 2047);
      queue_box(CMD_LOAD, -5, -5, 10, 10);
      queue_box(CMD_JUDGE, -5, -5, 10, 10);           // identical box, IoU of one
      queue_box(CMD_FRAME, 0, 0, 0, 0);
      wait_drained();

      // Random phases, each under its own register setting; the first phases
      // take the extremes, the threshold limits included.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin thr = 0;   height_limit = 0;    end
            1: begin thr = 511; height_limit = 2047; end
            2: begin thr = 256; height_limit = 1000; end
            3: begin thr = 1;   height_limit = 50;   end
            4: begin thr = 128; height_limit = 20;   end
            default: begin
               thr          = $urandom_range(1, 256);
               height_limit = $urandom_range(0, 2047);
            end
         endcase
         write_csr(CSR_IOU_THRESHOLD, thr);
         write_csr(CSR_LARGE_HEIGHT, height_limit);
         @(negedge clock);
         // The last two phases run at full rate on both sides.
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 10;
            default: idle_pct = 30;
         endcase
         if (p >= PHASES - 2) idle_pct = 0;
         stim_count = 0;
         queue_frame(p < 3);
         while (stim_count < PHASE_ITEMS) queue_frame($urandom_range(0, 7) == 0);
         wait_drained();
      end

      if (error_count == 0) begin
         $display("iou_detection_matcher_tb passed");
      end else begin
         $display("iou_detection_matcher_tb failed");
      end
      $finish;
   end

   // Hard limit on the run, many times the slowest legal run.
   initial begin
      #5_000_000;
      $display("iou_detection_matcher_tb failed");
      $finish;
   end

endmodule
